// ===== hw/rtl/pixel_channel_format_convert_defines.svh =====
// Assertion macros for the pixel channel format converter.
// Included by files that check their own logic; depends on nothing else.
`ifndef PIXEL_CHANNEL_FORMAT_CONVERT_DEFINES_SVH
`define PIXEL_CHANNEL_FORMAT_CONVERT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, checked at every rising edge out of reset.
`define PCFC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, checked at every rising edge out of reset.
`define PCFC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PCFC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg)
`define PCFC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== hw/rtl/pcfc_pkg.sv =====
// Shared constants, types and helper functions of the pixel channel format converter.
// Used by pcfc_lane, pixel_channel_format_convert and the testbench; depends on nothing.
package pcfc_pkg;

  // Channel and depth limits.
  localparam int unsigned MAX_CHANNELS      = 4;
  localparam int unsigned MAX_CHANNEL_DEPTH = 16;

  // Field widths.
  localparam int unsigned PIXEL_W    = 64;
  localparam int unsigned DEPTH_W    = 5;
  localparam int unsigned COUNT_W    = 3;
  localparam int unsigned FRAC_W     = 16;
  localparam int unsigned OFF_W      = 7;
  localparam int unsigned SUM_W      = 18;
  localparam int unsigned K_W        = 3;
  localparam int unsigned PROD_W     = SUM_W + FRAC_W;
  localparam int unsigned QUOT_W     = 18;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 20;
  localparam int unsigned SEL_W      = 4 * MAX_CHANNELS;
  localparam int unsigned DEPTHS_W   = DEPTH_W * MAX_CHANNELS;

  // Reciprocal of three, exact for quotients below 2^19.
  localparam int unsigned RECIP3_SHIFT = 20;
  localparam int unsigned RECIP3_W     = 19;
  localparam logic [RECIP3_W-1:0] RECIP3 = RECIP3_W'(((1 << RECIP3_SHIFT) + 2) / 3);

  // Reset values of the configuration registers.
  localparam logic [COUNT_W-1:0]  RST_SOURCE_COUNT  = COUNT_W'(4);
  localparam logic [COUNT_W-1:0]  RST_TARGET_COUNT  = COUNT_W'(4);
  localparam logic [DEPTHS_W-1:0] RST_SOURCE_DEPTHS = DEPTHS_W'(270600);
  localparam logic [DEPTHS_W-1:0] RST_TARGET_DEPTHS = DEPTHS_W'(270600);
  localparam logic [SEL_W-1:0]    RST_SOURCE_SELECT = SEL_W'(33825);
  localparam logic [MAX_CHANNELS-1:0] RST_ALPHA_FILL = MAX_CHANNELS'(8);

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SOURCE_COUNT  = 3'd0,
    REG_TARGET_COUNT  = 3'd1,
    REG_SOURCE_DEPTHS = 3'd2,
    REG_TARGET_DEPTHS = 3'd3,
    REG_SOURCE_SELECT = 3'd4,
    REG_ALPHA_FILL    = 3'd5
  } cfg_reg_e;

  // Stage enables handed to each scaling lane.
  typedef struct packed {
    logic s3_en;
    logic s4_en;
    logic s5_en;
  } lane_ctrl_t;

  // All ones in the low n bits, n from 0 to 16.
  function automatic logic [FRAC_W-1:0] full_mask(input logic [DEPTH_W-1:0] n);
    logic [FRAC_W:0] one_shl;
    one_shl = (FRAC_W+1)'(1) << n;
    return FRAC_W'(one_shl - (FRAC_W+1)'(1));
  endfunction

  // Widen a d-bit value (d from 1 to 16) to 16 bits by repeating its bits
  // from the top down. Each step doubles the number of copies.
  function automatic logic [FRAC_W-1:0] widen16(input logic [FRAC_W-1:0] v,
                                                input logic [DEPTH_W-1:0] d);
    logic [FRAC_W-1:0] t;
    logic [7:0]        dd;
    dd = {3'b000, d};
    t  = v << (DEPTH_W'(FRAC_W) - d);
    t  = t | (t >> dd);
    t  = t | (t >> (dd << 1));
    t  = t | (t >> (dd << 2));
    t  = t | (t >> (dd << 3));
    return t;
  endfunction

endpackage

// ===== hw/rtl/pcfc_lane.sv =====
// One destination channel of the converter: rescales the channel sum to the
// destination depth over three register stages. Depends on pcfc_pkg.
module pcfc_lane (
  input  logic                                clk_i,
  input  pcfc_pkg::lane_ctrl_t                ctrl_i,
  input  logic [pcfc_pkg::SUM_W-1:0]          sum_i,
  input  logic [pcfc_pkg::K_W-1:0]            cnt_i,
  input  logic                                fill_i,
  input  logic [pcfc_pkg::DEPTH_W-1:0]        depth_i,
  output logic [pcfc_pkg::FRAC_W-1:0]         val_o
);

  localparam int unsigned SumW   = pcfc_pkg::SUM_W;
  localparam int unsigned FracW  = pcfc_pkg::FRAC_W;
  localparam int unsigned ProdW  = pcfc_pkg::PROD_W;
  localparam int unsigned QuotW  = pcfc_pkg::QUOT_W;
  localparam int unsigned KW     = pcfc_pkg::K_W;
  localparam int unsigned R3W    = pcfc_pkg::RECIP3_W;
  localparam int unsigned R3S    = pcfc_pkg::RECIP3_SHIFT;

  logic [FracW-1:0] full;
  logic [ProdW-1:0] prod_d, prod_q;
  logic [KW-1:0]    k3_q, k4_q;
  logic [FracW-1:0] fillv3_q, fillv4_q;
  logic [QuotW-1:0] quot_d, quot_q;
  logic [FracW-1:0] val_d, val_q;

  // Stage 3: product of the channel sum and the full scale of the depth.
  always_comb begin
    full   = pcfc_pkg::full_mask(depth_i);
    prod_d = ProdW'(sum_i) * ProdW'(full);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.s3_en) begin
      prod_q   <= prod_d;
      k3_q     <= cnt_i;
      fillv3_q <= fill_i ? full : '0;
    end
  end

  // Stage 4: divide by 65535, using 65536 = 65535 + 1 twice and one correction.
  logic [SumW-1:0]  hi_a;
  logic [FracW-1:0] lo_b;
  logic [SumW:0]    part_r;
  logic [2:0]       hi_c;
  logic [FracW:0]   part_s;
  logic [SumW:0]    quot_w;

  always_comb begin
    hi_a   = prod_q[ProdW-1:FracW];
    lo_b   = prod_q[FracW-1:0];
    part_r = (SumW+1)'(hi_a) + (SumW+1)'(lo_b);
    hi_c   = part_r[SumW:FracW];
    part_s = (FracW+1)'(hi_c) + (FracW+1)'(part_r[FracW-1:0]);
    quot_w = (SumW+1)'(hi_a) + (SumW+1)'(hi_c)
           + (SumW+1)'(part_s >= (FracW+1)'(17'h0FFFF));
    quot_d = QuotW'(quot_w);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.s4_en) begin
      quot_q   <= quot_d;
      k4_q     <= k3_q;
      fillv4_q <= fillv3_q;
    end
  end

  // Stage 5: divide by the number of averaged sources, or take the fill value when there is none.
  logic [QuotW+R3W-1:0] third;

  always_comb begin
    third = (QuotW+R3W)'(quot_q) * (QuotW+R3W)'(pcfc_pkg::RECIP3);
    case (k4_q)
      3'd0:    val_d = fillv4_q;
      3'd1:    val_d = FracW'(quot_q);
      3'd2:    val_d = FracW'(quot_q >> 1);
      3'd3:    val_d = FracW'(third >> R3S);
      3'd4:    val_d = FracW'(quot_q >> 2);
      default: val_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.s5_en) begin
      val_q <= val_d;
    end
  end

  assign val_o = val_q;

endmodule

// ===== hw/rtl/pixel_channel_format_convert.sv =====
// Channel   | Direction | Signals                                | Beat
// ----------+-----------+----------------------------------------+-----------------------
// source    | in        | s_axis_tvalid/tready/tdata             | one packed source pixel
// target    | out       | m_axis_tvalid/tready/tdata             | one packed target pixel
// config    | in        | cfg_valid/ready, cfg_index, cfg_data   | one register write
//
// Six register stages: unpack and widen, sum, multiply, divide by 65535,
// divide by source count, pack. One pixel per cycle unless a stage is held.
// Each stage holds while the next one is full and stalled, so a stall on the
// target side fills the bubbles first and then backs up to s_axis_tready.
// Reset clears the valid bits and loads the configuration defaults.
// Depends on pcfc_pkg, pcfc_lane and pixel_channel_format_convert_defines.svh.
`include "pixel_channel_format_convert_defines.svh"

module pixel_channel_format_convert (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Source stream. tdata: source_pixel[63:0].
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [pcfc_pkg::PIXEL_W-1:0]         s_axis_tdata,
  // Target stream. tdata: target_pixel[63:0].
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [pcfc_pkg::PIXEL_W-1:0]         m_axis_tdata,
  // Configuration writes.
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [pcfc_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [pcfc_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  localparam int unsigned NCh     = pcfc_pkg::MAX_CHANNELS;
  localparam int unsigned DW      = pcfc_pkg::DEPTH_W;
  localparam int unsigned CW      = pcfc_pkg::COUNT_W;
  localparam int unsigned FracW   = pcfc_pkg::FRAC_W;
  localparam int unsigned OffW    = pcfc_pkg::OFF_W;
  localparam int unsigned SumW    = pcfc_pkg::SUM_W;
  localparam int unsigned KW      = pcfc_pkg::K_W;
  localparam int unsigned PixW    = pcfc_pkg::PIXEL_W;
  localparam int unsigned NStage  = 6;

  // Configuration registers.
  logic [CW-1:0]                 src_count_q, tgt_count_q;
  logic [pcfc_pkg::DEPTHS_W-1:0] src_depths_q, tgt_depths_q;
  logic [pcfc_pkg::SEL_W-1:0]    src_select_q;
  logic [NCh-1:0]                alpha_fill_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_count_q  <= pcfc_pkg::RST_SOURCE_COUNT;
      tgt_count_q  <= pcfc_pkg::RST_TARGET_COUNT;
      src_depths_q <= pcfc_pkg::RST_SOURCE_DEPTHS;
      tgt_depths_q <= pcfc_pkg::RST_TARGET_DEPTHS;
      src_select_q <= pcfc_pkg::RST_SOURCE_SELECT;
      alpha_fill_q <= pcfc_pkg::RST_ALPHA_FILL;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        pcfc_pkg::REG_SOURCE_COUNT:  src_count_q  <= cfg_data_i[CW-1:0];
        pcfc_pkg::REG_TARGET_COUNT:  tgt_count_q  <= cfg_data_i[CW-1:0];
        pcfc_pkg::REG_SOURCE_DEPTHS: src_depths_q <= cfg_data_i[pcfc_pkg::DEPTHS_W-1:0];
        pcfc_pkg::REG_TARGET_DEPTHS: tgt_depths_q <= cfg_data_i[pcfc_pkg::DEPTHS_W-1:0];
        pcfc_pkg::REG_SOURCE_SELECT: src_select_q <= cfg_data_i[pcfc_pkg::SEL_W-1:0];
        pcfc_pkg::REG_ALPHA_FILL:    alpha_fill_q <= cfg_data_i[NCh-1:0];
        default: ;
      endcase
    end
  end

  // Effective depths and bit offsets of each channel, from the configuration.
  logic [CW-1:0]   src_cnt, tgt_cnt;
  logic [DW-1:0]   src_dep [NCh];
  logic [DW-1:0]   tgt_dep [NCh];
  logic [OffW-1:0] src_off [NCh];
  logic [OffW-1:0] tgt_off [NCh];

  always_comb begin
    src_cnt = (src_count_q > CW'(NCh)) ? CW'(NCh) : src_count_q;
    tgt_cnt = (tgt_count_q > CW'(NCh)) ? CW'(NCh) : tgt_count_q;
    for (int i = 0; i < NCh; i++) begin
      src_dep[i] = src_depths_q[DW*i +: DW];
      if (src_dep[i] > DW'(pcfc_pkg::MAX_CHANNEL_DEPTH)) begin
        src_dep[i] = DW'(pcfc_pkg::MAX_CHANNEL_DEPTH);
      end
      if (CW'(i) >= src_cnt) begin
        src_dep[i] = '0;
      end
      tgt_dep[i] = tgt_depths_q[DW*i +: DW];
      if (tgt_dep[i] > DW'(pcfc_pkg::MAX_CHANNEL_DEPTH)) begin
        tgt_dep[i] = DW'(pcfc_pkg::MAX_CHANNEL_DEPTH);
      end
      if (CW'(i) >= tgt_cnt) begin
        tgt_dep[i] = '0;
      end
    end
    // The last channel sits at bit 0; each earlier one sits above the rest.
    src_off[NCh-1] = '0;
    tgt_off[NCh-1] = '0;
    for (int i = NCh - 2; i >= 0; i--) begin
      src_off[i] = src_off[i+1] + OffW'(src_dep[i+1]);
      tgt_off[i] = tgt_off[i+1] + OffW'(tgt_dep[i+1]);
    end
  end

  // Valid bits and the ready chain; a stage loads when it is empty or drains.
  logic [NStage-1:0] vld_q, vld_d, rdy;

  always_comb begin
    rdy[NStage-1] = !vld_q[NStage-1] || m_axis_tready;
    for (int i = NStage - 2; i >= 0; i--) begin
      rdy[i] = !vld_q[i] || rdy[i+1];
    end
    vld_d[0] = rdy[0] ? s_axis_tvalid : vld_q[0];
    for (int i = 1; i < NStage; i++) begin
      vld_d[i] = rdy[i] ? vld_q[i-1] : vld_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign s_axis_tready = rdy[0];

  // Stage 1: cut the source channels out of the pixel and widen each to 16 bits.
  logic [FracW-1:0] frac_d   [NCh];
  logic [FracW-1:0] frac_q   [NCh];
  logic [NCh-1:0]   usable_d, usable_q;

  always_comb begin
    for (int i = 0; i < NCh; i++) begin
      logic [FracW-1:0] raw;
      raw         = FracW'(s_axis_tdata >> src_off[i]) & pcfc_pkg::full_mask(src_dep[i]);
      usable_d[i] = (src_dep[i] != '0);
      frac_d[i]   = usable_d[i] ? pcfc_pkg::widen16(raw, src_dep[i]) : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      frac_q   <= frac_d;
      usable_q <= usable_d;
    end
  end

  // Stage 2: sum and count the selected sources of each destination channel.
  logic [SumW-1:0] sum_d [NCh];
  logic [SumW-1:0] sum_q [NCh];
  logic [KW-1:0]   cnt_d [NCh];
  logic [KW-1:0]   cnt_q [NCh];

  always_comb begin
    for (int t = 0; t < NCh; t++) begin
      logic [NCh-1:0] pick;
      pick     = src_select_q[4*t +: NCh] & usable_q;
      sum_d[t] = '0;
      cnt_d[t] = '0;
      for (int j = 0; j < NCh; j++) begin
        if (pick[j]) begin
          sum_d[t] = sum_d[t] + SumW'(frac_q[j]);
          cnt_d[t] = cnt_d[t] + KW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      sum_q <= sum_d;
      cnt_q <= cnt_d;
    end
  end

  // Stages 3 to 5: one scaling lane per destination channel.
  pcfc_pkg::lane_ctrl_t lane_ctrl;
  logic [FracW-1:0]     lane_val [NCh];

  assign lane_ctrl.s3_en = rdy[2];
  assign lane_ctrl.s4_en = rdy[3];
  assign lane_ctrl.s5_en = rdy[4];

  for (genvar t = 0; t < NCh; t++) begin : g_lane
    pcfc_lane u_lane (
      .clk_i   (clk_i),
      .ctrl_i  (lane_ctrl),
      .sum_i   (sum_q[t]),
      .cnt_i   (cnt_q[t]),
      .fill_i  (alpha_fill_q[t]),
      .depth_i (tgt_dep[t]),
      .val_o   (lane_val[t])
    );
  end

  // Stage 6: pack the destination channels into the output register.
  logic [PixW-1:0] out_d, out_q;

  always_comb begin
    out_d = '0;
    for (int t = 0; t < NCh; t++) begin
      out_d = out_d | (PixW'(lane_val[t]) << tgt_off[t]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[5]) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = vld_q[NStage-1];
  assign m_axis_tdata  = out_q;

  // Checks on the stage control.
  logic in_acc, out_acc;
  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  `PCFC_ASSERT_NOW(a_full_backpressure, clk_i, rst_ni, (&vld_q) && !m_axis_tready, !s_axis_tready, "pipeline full and stalled but input still ready")
  `PCFC_ASSERT_NEXT(a_accept_lands, clk_i, rst_ni, in_acc, vld_q[0], "accepted beat did not reach the first stage")
  `PCFC_ASSERT_NEXT(a_beat_count, clk_i, rst_ni, 1'b1, $countones(vld_q) == $countones($past(vld_q)) + int'($past(in_acc)) - int'($past(out_acc)), "beats lost or duplicated inside the pipeline")

endmodule

// ===== tb/tb_pixel_channel_format_convert.sv =====
// Self-checking testbench for pixel_channel_format_convert: directed and random pixels
// under many channel formats, checked against a fixed-point converter kept in the bench.
// Depends on pcfc_pkg and the pixel_channel_format_convert RTL.
`timescale 1ns / 1ps

module tb_pixel_channel_format_convert;
  import pcfc_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned RANDOM_ITEMS = 650;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [PIXEL_W-1:0]    s_axis_tdata  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [PIXEL_W-1:0]    m_axis_tdata;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;

  // Format copy used to predict each target pixel.
  logic [COUNT_W-1:0]      fmt_src_count  = RST_SOURCE_COUNT;
  logic [COUNT_W-1:0]      fmt_dst_count  = RST_TARGET_COUNT;
  logic [DEPTHS_W-1:0]     fmt_src_depths = RST_SOURCE_DEPTHS;
  logic [DEPTHS_W-1:0]     fmt_dst_depths = RST_TARGET_DEPTHS;
  logic [SEL_W-1:0]        fmt_select     = RST_SOURCE_SELECT;
  logic [MAX_CHANNELS-1:0] fmt_alpha      = RST_ALPHA_FILL;

  logic [PIXEL_W-1:0] source_pixel_q [$];
  logic [PIXEL_W-1:0] target_expect_q [$];
  int unsigned queued_cnt   = 0;
  int unsigned accepted_cnt = 0;
  int unsigned checked_cnt  = 0;
  int unsigned format_cnt   = 0;
  int unsigned fail_cnt     = 0;
  int unsigned cycle_cnt    = 0;
  bit          src_fire     = 1'b0;
  bit          dst_fire     = 1'b0;

  pixel_channel_format_convert u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // source_pixel[63:0]
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // target_pixel[63:0]
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Free-running clock.
  always #5 clk_i = ~clk_i;

  // Channel depth with saturation at the maximum depth.
  function automatic int unsigned chan_depth(input logic [DEPTHS_W-1:0] depths,
                                             input int unsigned ch);
    int unsigned d;
    d = int'(depths[DEPTH_W*ch +: DEPTH_W]);
    return (d > MAX_CHANNEL_DEPTH) ? MAX_CHANNEL_DEPTH : d;
  endfunction

  // Channel count with saturation at the maximum count.
  function automatic int unsigned chan_count(input logic [COUNT_W-1:0] cnt);
    return (cnt > MAX_CHANNELS) ? MAX_CHANNELS : int'(cnt);
  endfunction

  // Stretch a d-bit value to a 16-bit fraction by repeating its bits.
  function automatic logic [15:0] replicate_to_16(input logic [15:0] v, input int unsigned d);
    logic [31:0] acc;
    int unsigned filled;
    acc    = '0;
    filled = 0;
    while (filled < 16) begin
      acc    = (acc << d) | 32'(v);
      filled = filled + d;
    end
    return 16'(acc >> (filled - 16));
  endfunction

  // Expected target pixel for one source pixel under the current format.
  function automatic logic [PIXEL_W-1:0] convert_pixel(input logic [PIXEL_W-1:0] src);
    logic [15:0]        frac [MAX_CHANNELS];
    bit                 usable [MAX_CHANNELS];
    int unsigned        n_src, n_dst, total, stop, d, sel, k;
    logic [PIXEL_W-1:0] full, sum, val, result;
    n_src  = chan_count(fmt_src_count);
    n_dst  = chan_count(fmt_dst_count);
    result = '0;
    total  = 0;
    for (int i = 0; i < n_src; i++) total += chan_depth(fmt_src_depths, i);
    for (int i = 0; i < MAX_CHANNELS; i++) begin
      frac[i]   = '0;
      usable[i] = 1'b0;
    end
    // Unpack the source channels, channel 0 in the top used bits.
    stop = 0;
    for (int i = 0; i < n_src; i++) begin
      d = chan_depth(fmt_src_depths, i);
      if (d != 0) begin
        stop      = stop + d;
        frac[i]   = replicate_to_16(16'((src >> (total - stop)) & ((64'd1 << d) - 1)), d);
        usable[i] = 1'b1;
      end
    end
    // Average, rescale and pack each target channel.
    total = 0;
    for (int i = 0; i < n_dst; i++) total += chan_depth(fmt_dst_depths, i);
    stop = 0;
    for (int i = 0; i < n_dst; i++) begin
      d = chan_depth(fmt_dst_depths, i);
      if (d != 0) begin
        stop = stop + d;
        full = (64'd1 << d) - 1;
        sel  = int'(fmt_select[4*i +: 4]);
        sum  = '0;
        k    = 0;
        for (int j = 0; j < MAX_CHANNELS; j++) begin
          if (sel[j] && usable[j]) begin
            sum = sum + 64'(frac[j]);
            k   = k + 1;
          end
        end
        if (k == 0) val = fmt_alpha[i] ? full : '0;
        else        val = (sum * full) / (64'd65535 * 64'(k));
        result = result | ((val & full) << (total - stop));
      end
    end
    return result;
  endfunction

  // Monitor: record accepted beats, track format writes and check results.
  always @(posedge clk_i) begin
    src_fire <= rst_ni && s_axis_tvalid && s_axis_tready;
    dst_fire <= rst_ni && m_axis_tvalid && m_axis_tready;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_reg_e'(cfg_index_i))
          REG_SOURCE_COUNT:  fmt_src_count  = cfg_data_i[COUNT_W-1:0];
          REG_TARGET_COUNT:  fmt_dst_count  = cfg_data_i[COUNT_W-1:0];
          REG_SOURCE_DEPTHS: fmt_src_depths = cfg_data_i[DEPTHS_W-1:0];
          REG_TARGET_DEPTHS: fmt_dst_depths = cfg_data_i[DEPTHS_W-1:0];
          REG_SOURCE_SELECT: fmt_select     = cfg_data_i[SEL_W-1:0];
          REG_ALPHA_FILL:    fmt_alpha      = cfg_data_i[MAX_CHANNELS-1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        target_expect_q.insert(target_expect_q.size(), convert_pixel(s_axis_tdata));
        accepted_cnt++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (target_expect_q.size() == 0) begin
          $display("%0t: unexpected target pixel %h", $time, m_axis_tdata);
          fail_cnt++;
        end else begin
          logic [PIXEL_W-1:0] want;
          want = target_expect_q.pop_front();
          checked_cnt++;
          if (m_axis_tdata !== want) begin
            $display("%0t: target_pixel mismatch: expected %h, got %h",
                     $time, want, m_axis_tdata);
            fail_cnt++;
          end
        end
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d pixels outstanding", $time, target_expect_q.size());
      $display("status: fail");
      $finish;
    end
  end

  // Source driver: one pixel per beat with random gaps, bursts without gaps.
  int unsigned src_wait  = 0;
  bit          src_burst = 1'b0;
  always @(negedge clk_i) begin
    if (rst_ni && !(s_axis_tvalid && !src_fire)) begin
      if (src_wait > 0) begin
        src_wait--;
        s_axis_tvalid <= 1'b0;
      end else if (source_pixel_q.size() > 0) begin
        s_axis_tdata  <= source_pixel_q.pop_front();
        s_axis_tvalid <= 1'b1;
        if ($urandom_range(0, 39) == 0) src_burst = !src_burst;
        src_wait = src_burst ? 0 : $urandom_range(0, 16);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Target side stalls: a random wait after each accepted beat.
  int unsigned dst_wait  = 0;
  bit          dst_burst = 1'b0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (dst_fire) begin
        if ($urandom_range(0, 39) == 0) dst_burst = !dst_burst;
        dst_wait = dst_burst ? 0 : $urandom_range(0, 16);
      end
      if (dst_wait > 0) begin
        dst_wait--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  function automatic logic [DEPTHS_W-1:0] pack_depths(input int unsigned d0, d1, d2, d3);
    return {5'(d3), 5'(d2), 5'(d1), 5'(d0)};
  endfunction

  task automatic queue_pixel(input logic [PIXEL_W-1:0] pix);
    source_pixel_q.insert(source_pixel_q.size(), pix);
    queued_cnt++;
  endtask

  // Wait until every queued pixel has been accepted and its result checked.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (accepted_cnt != queued_cnt || target_expect_q.size() != 0);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Load a whole channel format; only called with the pipeline empty.
  task automatic set_format(input logic [COUNT_W-1:0] sc, tc,
                            input logic [DEPTHS_W-1:0] sd, td,
                            input logic [SEL_W-1:0] sel,
                            input logic [MAX_CHANNELS-1:0] alpha);
    wait_drained();
    write_reg(REG_SOURCE_COUNT, CFG_DATA_W'(sc));
    write_reg(REG_TARGET_COUNT, CFG_DATA_W'(tc));
    write_reg(REG_SOURCE_DEPTHS, CFG_DATA_W'(sd));
    write_reg(REG_TARGET_DEPTHS, CFG_DATA_W'(td));
    write_reg(REG_SOURCE_SELECT, CFG_DATA_W'(sel));
    write_reg(REG_ALPHA_FILL, CFG_DATA_W'(alpha));
    format_cnt++;
  endtask

  function automatic logic [PIXEL_W-1:0] random_pixel();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  function automatic int unsigned random_depth();
    return ($urandom_range(0, 5) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 16);
  endfunction

  function automatic logic [COUNT_W-1:0] random_count();
    return ($urandom_range(0, 4) == 0) ? COUNT_W'($urandom_range(0, 7))
                                       : COUNT_W'($urandom_range(1, 4));
  endfunction

  // Stimulus: reset, directed formats, then random formats and pixels.
  initial begin
    int unsigned random_sent, n;
    random_sent = 0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Default format straight out of reset.
    queue_pixel(64'h0);
    queue_pixel('1);
    queue_pixel(64'h0000_0000_FFFF_FFFF);
    queue_pixel(64'hFFFF_FFFF_0000_0000);
    queue_pixel(64'h0000_0000_80FF_7F01);

    // Widest format, every target channel averaging all four sources.
    set_format(3'd4, 3'd4, pack_depths(16, 16, 16, 16), pack_depths(16, 16, 16, 16),
               16'hFFFF, 4'hF);
    queue_pixel(64'h0);
    queue_pixel('1);
    queue_pixel(64'h8000_7FFF_0001_FFFE);

    // Three-way average, odd depths, an alpha channel with no source.
    set_format(3'd3, 3'd4, pack_depths(5, 6, 5, 0), pack_depths(8, 8, 8, 8),
               16'h0137, 4'h8);
    queue_pixel('1);
    repeat (3) queue_pixel({$urandom(), $urandom()});

    // Counts and depths above their maximum saturate.
    set_format(3'd7, 3'd5, pack_depths(31, 17, 3, 12), pack_depths(20, 1, 16, 9),
               16'hF0A5, 4'h6);
    queue_pixel('1);
    repeat (2) queue_pixel({$urandom(), $urandom()});

    // Selection of missing sources, and a target channel of depth zero.
    set_format(3'd2, 3'd3, pack_depths(12, 4, 16, 16), pack_depths(4, 12, 0, 7),
               16'hFFFC, 4'h1);
    queue_pixel('1);
    repeat (2) queue_pixel({$urandom(), $urandom()});

    // No source channels at all: alpha fill only.
    set_format(3'd0, 3'd4, pack_depths(8, 8, 8, 8), pack_depths(8, 8, 8, 8),
               16'hFFFF, 4'h5);
    queue_pixel('1);
    queue_pixel({$urandom(), $urandom()});

    // No target channels: the target pixel is zero.
    set_format(3'd4, 3'd0, pack_depths(8, 8, 8, 8), pack_depths(8, 8, 8, 8),
               16'hFFFF, 4'hF);
    queue_pixel('1);
    queue_pixel({$urandom(), $urandom()});

    // Single one-bit source fanned out to narrow and wide targets.
    set_format(3'd1, 3'd4, pack_depths(1, 0, 0, 0), pack_depths(1, 16, 0, 2),
               16'h1111, 4'h0);
    queue_pixel(64'h1);
    queue_pixel(64'h0);

    // Random formats, with an occasional narrowest or widest one.
    while (random_sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 7))
        0: set_format(3'd4, 3'd4, pack_depths(16, 16, 16, 16),
                      pack_depths(16, 16, 16, 16), 16'hFFFF, 4'hF);
        1: set_format(3'd1, 3'd1, pack_depths(1, 1, 1, 1), pack_depths(1, 1, 1, 1),
                      16'h0001, 4'h0);
        default: set_format(random_count(), random_count(),
                            pack_depths(random_depth(), random_depth(), random_depth(),
                                        random_depth()),
                            pack_depths(random_depth(), random_depth(), random_depth(),
                                        random_depth()),
                            16'($urandom_range(0, 65535)), 4'($urandom_range(0, 15)));
      endcase
      n = $urandom_range(30, 70);
      repeat (n) queue_pixel(random_pixel());
      random_sent += n;
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (target_expect_q.size() != 0) begin
      $display("%0t: %0d target pixels never arrived", $time, target_expect_q.size());
      fail_cnt++;
    end
    $display("Converted %0d pixels under %0d channel formats plus the reset default.",
             checked_cnt, format_cnt);
    $display("Mismatches and stray results: %0d.", fail_cnt);
    if (fail_cnt == 0) $display("status: pass");
    else               $display("status: fail");
    $finish;
  end

endmodule
